// ===== design/md5_pkg.sv =====
`default_nettype none
package md5_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned ROUNDS      = 64;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Words 14 and 15 hold the bit length.
    localparam logic [3:0] LEN_LO_IDX = 4'd14;
    localparam logic [3:0] LEN_HI_IDX = 4'd15;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } md5_words_t;

    localparam md5_words_t IV_WORDS = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD_HEAD,
        ST_PAD_FILL,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } md5_state_t;

    localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Message word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        case (r[5:4])
            2'd0: idx = lo;
            2'd1: idx = (lo << 2) + lo + 4'd1;
            2'd2: idx = (lo << 1) + lo + 4'd5;
            2'd3: idx = (lo << 3) - lo;
            default: idx = lo;
        endcase
        return idx;
    endfunction

    // Left rotate amount of a round.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            4'hf: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/md5_message_digest_top.sv =====
`default_nettype none
// A byte that does not close a 64-byte block is only packed or stored; a byte that closes one
// starts the compression (load, 64 rounds, add), during which s_ready is low.
// End of message: pad head, up to 13 zero writes, fill exit, 2 length writes, then the
// compression; a tail of 56+ bytes first zero-fills and compresses its block, then pads another.
// Throughput is bounded by the single round unit: 64 rounds per block, one per cycle.
// Reset (aresetn low, synchronous) restores the IV and clears the byte count; no clearing pass.
module md5_message_digest_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_end_of_message,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic             m_last_word
);

    md5_pkg::md5_state_t state_reg, state_next;
    md5_pkg::md5_state_t ret_reg, ret_next;       // where to go after the add step

    logic [md5_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [31:0]                 word_reg, word_next;  // partial word being packed
    logic [4:0]                  fill_idx_reg, fill_idx_next;
    logic                        fill_two_reg, fill_two_next; // fill whole block, then pad again
    logic [5:0]                  round_reg, round_next;
    logic [1:0]                  emit_idx_reg, emit_idx_next;
    md5_pkg::md5_words_t         cv_reg, cv_next;     // chaining value
    md5_pkg::md5_words_t         wk_reg, wk_next;     // working words of the compression
    md5_pkg::md5_words_t         round_out;

    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;

    logic [1:0]  lane;
    logic [31:0] head_word;
    logic [4:0]  fill_limit;

    // Block buffer: written one word at a time, read once per round.
    md5_ram #(
        .WIDTH (md5_pkg::WORD_W),
        .DEPTH (md5_pkg::BLOCK_WORDS)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5_round u_round (
        .round_idx (round_reg),
        .words_in  (wk_reg),
        .msg_word  (ram_rdata),
        .words_out (round_out)
    );

    assign lane       = count_reg[1:0];
    assign fill_limit = fill_two_reg ? 5'd16 : {1'b0, md5_pkg::LEN_LO_IDX};

    // Pad word: keep bytes already packed, place the 0x80 marker, zero the rest.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < lane) begin
                head_word[8*j +: 8] = word_reg[8*j +: 8];
            end else if (2'(j) == lane) begin
                head_word[8*j +: 8] = md5_pkg::PAD_BYTE;
            end else begin
                head_word[8*j +: 8] = 8'h00;
            end
        end
    end

    // Prefetch the message word of the next round; the registered read delivers it in the following cycle.
    always_comb begin
        if (state_reg == md5_pkg::ST_ROUND) begin
            ram_raddr = md5_pkg::msg_index(round_reg + 6'd1);
        end else begin
            ram_raddr = md5_pkg::msg_index(6'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= md5_pkg::ST_IDLE;
            ret_reg      <= md5_pkg::ST_IDLE;
            count_reg    <= '0;
            fill_idx_reg <= '0;
            fill_two_reg <= 1'b0;
            round_reg    <= '0;
            emit_idx_reg <= '0;
            cv_reg       <= md5_pkg::IV_WORDS;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            count_reg    <= count_next;
            fill_idx_reg <= fill_idx_next;
            fill_two_reg <= fill_two_next;
            round_reg    <= round_next;
            emit_idx_reg <= emit_idx_next;
            cv_reg       <= cv_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        wk_reg   <= wk_next;
    end

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        count_next    = count_reg;
        word_next     = word_reg;
        fill_idx_next = fill_idx_reg;
        fill_two_next = fill_two_reg;
        round_next    = round_reg;
        emit_idx_next = emit_idx_reg;
        cv_next       = cv_reg;
        wk_next       = wk_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;

        case (state_reg)
            md5_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_byte_present) begin
                        // Pack the byte little-endian; store the word once full.
                        count_next = count_reg + 1'b1;
                        word_next[8*lane +: 8] = s_msg_byte;
                        if (lane == 2'd3) begin
                            ram_we    = 1'b1;
                            ram_waddr = count_reg[5:2];
                            ram_wdata = {s_msg_byte, word_reg[23:0]};
                        end
                        if (count_reg[5:0] == 6'd63) begin
                            state_next = md5_pkg::ST_LOAD;
                            ret_next   = s_end_of_message ? md5_pkg::ST_PAD_HEAD
                                                          : md5_pkg::ST_IDLE;
                        end else if (s_end_of_message) begin
                            state_next = md5_pkg::ST_PAD_HEAD;
                        end
                    end else if (s_end_of_message) begin
                        state_next = md5_pkg::ST_PAD_HEAD;
                    end
                end
            end

            md5_pkg::ST_PAD_HEAD: begin
                ram_we        = 1'b1;
                ram_waddr     = count_reg[5:2];
                ram_wdata     = head_word;
                fill_idx_next = {1'b0, count_reg[5:2]} + 5'd1;
                // No room left for the length: pad this block out and use another.
                fill_two_next = (count_reg[5:3] == 3'b111);
                state_next    = md5_pkg::ST_PAD_FILL;
            end

            md5_pkg::ST_PAD_FILL: begin
                if (fill_idx_reg < fill_limit) begin
                    ram_we        = 1'b1;
                    ram_waddr     = fill_idx_reg[3:0];
                    ram_wdata     = '0;
                    fill_idx_next = fill_idx_reg + 5'd1;
                end else if (fill_two_reg) begin
                    fill_idx_next = '0;
                    fill_two_next = 1'b0;
                    state_next    = md5_pkg::ST_LOAD;
                    ret_next      = md5_pkg::ST_PAD_FILL;
                end else begin
                    state_next = md5_pkg::ST_LEN_LO;
                end
            end

            md5_pkg::ST_LEN_LO: begin
                ram_we     = 1'b1;
                ram_waddr  = md5_pkg::LEN_LO_IDX;
                ram_wdata  = {count_reg[28:0], 3'b000};
                state_next = md5_pkg::ST_LEN_HI;
            end

            md5_pkg::ST_LEN_HI: begin
                ram_we     = 1'b1;
                ram_waddr  = md5_pkg::LEN_HI_IDX;
                ram_wdata  = count_reg[60:29];
                state_next = md5_pkg::ST_LOAD;
                ret_next   = md5_pkg::ST_EMIT;
            end

            md5_pkg::ST_LOAD: begin
                wk_next    = cv_reg;
                round_next = '0;
                state_next = md5_pkg::ST_ROUND;
            end

            md5_pkg::ST_ROUND: begin
                wk_next    = round_out;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(md5_pkg::ROUNDS - 1)) begin
                    state_next = md5_pkg::ST_ADD;
                end
            end

            md5_pkg::ST_ADD: begin
                cv_next.a  = cv_reg.a + wk_reg.a;
                cv_next.b  = cv_reg.b + wk_reg.b;
                cv_next.c  = cv_reg.c + wk_reg.c;
                cv_next.d  = cv_reg.d + wk_reg.d;
                state_next = ret_reg;
            end

            md5_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    emit_idx_next = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == 2'd3) begin
                        // Last digest word taken: start a fresh message.
                        cv_next    = md5_pkg::IV_WORDS;
                        count_next = '0;
                        ret_next   = md5_pkg::ST_IDLE;
                        state_next = md5_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (emit_idx_reg)
            2'd0: m_digest_word = cv_reg.a;
            2'd1: m_digest_word = cv_reg.b;
            2'd2: m_digest_word = cv_reg.c;
            2'd3: m_digest_word = cv_reg.d;
            default: m_digest_word = cv_reg.a;
        endcase
    end

    assign m_last_word = (emit_idx_reg == 2'd3);

`ifndef SYNTH
    // The buffer must not change while rounds read it.
    a_no_write_in_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5_pkg::ST_ROUND) |-> !ram_we)
        else $error("block buffer written during compression");

    // Input and result sides never both open.
    a_one_side_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while digest pending");

    // Final add step is followed by the digest.
    a_add_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5_pkg::ST_ADD && ret_reg == md5_pkg::ST_EMIT) |=> m_valid)
        else $error("digest not presented after final compression");

    // Taking the last word starts a new message with zero length.
    a_restart_after_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (count_reg == '0 && s_ready))
        else $error("byte count not cleared after digest");
`endif

endmodule
`default_nettype wire

// ===== design/md5_ram.sv =====
`default_nettype none
module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/md5_round.sv =====
`default_nettype none
module md5_round (
    input  wire logic [5:0]               round_idx,
    input  wire md5_pkg::md5_words_t      words_in,
    input  wire logic [md5_pkg::WORD_W-1:0] msg_word,
    output md5_pkg::md5_words_t           words_out
);

    logic [md5_pkg::WORD_W-1:0] f;
    logic [md5_pkg::WORD_W-1:0] sum;
    logic [md5_pkg::WORD_W-1:0] rot;
    logic [4:0]                 amt;

    always_comb begin
        case (round_idx[5:4])
            2'd0: f = (words_in.b & words_in.c) | (~words_in.b & words_in.d);
            2'd1: f = (words_in.b & words_in.d) | (words_in.c & ~words_in.d);
            2'd2: f = words_in.b ^ words_in.c ^ words_in.d;
            2'd3: f = words_in.c ^ (words_in.b | ~words_in.d);
            default: f = '0;
        endcase
        sum = words_in.a + f + md5_pkg::K_TABLE[round_idx] + msg_word;
        amt = md5_pkg::rot_amount(round_idx);
        rot = (sum << amt) | (sum >> (6'd32 - {1'b0, amt}));
        // Rotate the working words: a gets d, c gets b, d gets c.
        words_out.a = words_in.d;
        words_out.b = words_in.b + rot;
        words_out.c = words_in.b;
        words_out.d = words_in.c;
    end

endmodule
`default_nettype wire
